>>> hw/rtl/pnc_pkg.sv
package pnc_pkg;

    // coordinate format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    // magnitude of a coordinate difference
    localparam int MAG_W     = COORD_W + 1;

    // near plane reset value, 1.0 in fixed point
    localparam logic [COORD_W-1:0] ZLIM_RESET = COORD_W'(64'd1 << FRAC_BITS);

    // register map
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_Z_LIMIT = APB_ADDR_W'(0);

    // request to the shared multiply-divide unit
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] den;
    } t_md_req;

endpackage

>>> hw/rtl/pnc_muldiv.sv
module pnc_muldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pnc_pkg::t_md_req              i_req,
    output logic                          o_done,
    output logic [pnc_pkg::MAG_W-1:0]     o_quot
);

    localparam int MW    = pnc_pkg::MAG_W;
    localparam int SUM_W = MW + 2;
    localparam int CNT_W = $clog2(MW);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [MW-1:0]    r_hi, n_hi;
    logic [MW-1:0]    r_lo, n_lo;
    logic [MW-1:0]    r_num, n_num;
    logic [MW-1:0]    r_den, n_den;

    logic [SUM_W-1:0] w_a, w_b, w_sum;
    logic             w_cin;
    logic [MW:0]      w_trial;
    logic             w_ge;

    // shared adder: accumulate in the multiply phase, trial subtract in the divide phase
    always_comb begin
        w_trial = {r_hi, r_lo[MW-1]};
        if (r_state == U_DIV) begin
            w_a   = {1'b0, w_trial};
            w_b   = ~{2'b00, r_den};
            w_cin = 1'b1;
        end else begin
            w_a   = {2'b00, r_hi};
            w_b   = r_lo[0] ? {2'b00, r_num} : '0;
            w_cin = 1'b0;
        end
        w_sum = w_a + w_b + SUM_W'(w_cin);
        w_ge  = ~w_sum[SUM_W-1];
    end

    // sequencer: shift-add multiply, then restoring divide of the product
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_num   = r_num;
        n_den   = r_den;
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_hi    = '0;
                    n_lo    = i_req.mag;
                    n_num   = i_req.num;
                    n_den   = i_req.den;
                    n_cnt   = CNT_W'(MW - 1);
                    n_state = U_MUL;
                end
            end
            U_MUL: begin
                n_hi = w_sum[MW:1];
                n_lo = {w_sum[0], r_lo[MW-1:1]};
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(MW - 1);
                    n_state = U_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            U_DIV: begin
                n_hi = w_ge ? w_sum[MW-1:0] : w_trial[MW-1:0];
                n_lo = {r_lo[MW-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule

>>> hw/rtl/polygon_near_plane_clip.sv
// Each intersection result works out two axes in turn on the muldiv unit, each axis
// taking 33 multiply steps and 33 divide steps.
// The input is not ready while a vertex is in work; the output register lets the last
// result wait to be taken.
// Reset: synchronous active low; clears the sequencer, polygon state and z_limit to 1.0.
module polygon_near_plane_clip (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // vertex requests
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pnc_pkg::COORD_W-1:0]     i_vert_x,
    input  logic signed [pnc_pkg::COORD_W-1:0]     i_vert_y,
    input  logic signed [pnc_pkg::COORD_W-1:0]     i_vert_z,
    input  logic                                   i_last_vertex,
    // result requests
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pnc_pkg::COORD_W-1:0]     o_out_x,
    output logic signed [pnc_pkg::COORD_W-1:0]     o_out_y,
    output logic signed [pnc_pkg::COORD_W-1:0]     o_out_z,
    output logic                                   o_has_vertex,
    output logic                                   o_polygon_end,
    output logic                                   o_polygon_empty,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pnc_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int CW = pnc_pkg::COORD_W;
    localparam int MW = pnc_pkg::MAG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MDX  = 3'd2;
    localparam logic [2:0] S_MDY  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // result slots of one vertex: edge cut, edge end, closing cut, closing end
    localparam logic [1:0] SLOT_CUT1 = 2'd0;
    localparam logic [1:0] SLOT_END1 = 2'd1;
    localparam logic [1:0] SLOT_CUT2 = 2'd2;
    localparam logic [1:0] SLOT_END2 = 2'd3;

    // control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_zlim, n_zlim;
    logic          r_in_poly, n_in_poly;
    logic          r_any, n_any;
    logic          r_last, n_last;
    logic [3:0]    r_mask, n_mask;
    logic [1:0]    r_slot, n_slot;
    logic          r_step_out, n_step_out;
    logic          r_out_valid, n_out_valid;

    // vertex registers
    logic [CW-1:0] r_cur_x, r_cur_y, r_cur_z, n_cur_x, n_cur_y, n_cur_z;
    logic [CW-1:0] r_prev_x, r_prev_y, r_prev_z, n_prev_x, n_prev_y, n_prev_z;
    logic [CW-1:0] r_first_x, r_first_y, r_first_z, n_first_x, n_first_y, n_first_z;

    // staged result and output register
    logic [CW-1:0] r_res_x, r_res_y, r_res_z, n_res_x, n_res_y, n_res_z;
    logic          r_res_has, r_res_end, r_res_empty, n_res_has, n_res_end, n_res_empty;
    logic [CW-1:0] r_out_x, r_out_y, r_out_z, n_out_x, n_out_y, n_out_z;
    logic          r_out_has, r_out_end, r_out_empty, n_out_has, n_out_end, n_out_empty;

    // edge operands and unit link
    logic              w_close;
    logic [CW-1:0]     w_sx, w_sy, w_sz, w_ex, w_ey, w_ez;
    logic [MW-1:0]     w_num, w_den, w_mag_x, w_mag_y;
    logic              w_neg_x, w_neg_y;
    logic [CW-1:0]     w_first_z_eff;
    logic              w_vis_cur, w_vis_prev, w_vis_first;
    logic [1:0]        w_scan_slot;
    logic [3:0]        w_rest;
    logic              w_in_acc, w_cfg_wr;
    pnc_pkg::t_md_req  w_md_req;
    logic              w_md_done;
    logic [MW-1:0]     w_md_quot;

    function automatic logic f_vis(input logic [CW-1:0] z, input logic [CW-1:0] lim);
        return $signed(z) >= $signed(lim);
    endfunction

    // magnitude of b - a
    function automatic logic [MW-1:0] f_absdiff(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [MW-1:0] d;
        d = {b[CW-1], b} - {a[CW-1], a};
        return d[MW-1] ? (~d + 1'b1) : d;
    endfunction

    pnc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_done  (w_md_done),
        .o_quot  (w_md_quot)
    );

    // configuration access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == pnc_pkg::ADDR_Z_LIMIT);
    assign prdata   = (paddr == pnc_pkg::ADDR_Z_LIMIT) ? r_zlim : '0;

    // handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // visibility of the arriving vertex against previous and first
    always_comb begin
        w_first_z_eff = r_in_poly ? r_first_z : i_vert_z;
        w_vis_cur     = f_vis(i_vert_z, r_zlim);
        w_vis_prev    = f_vis(r_prev_z, r_zlim);
        w_vis_first   = f_vis(w_first_z_eff, r_zlim);
    end

    // edge endpoints: edge runs prev to cur, closing edge cur to first
    // while a slot is being picked, the picked slot already selects the edge
    always_comb begin
        w_close = (r_state == S_SCAN) ? w_scan_slot[1] : r_slot[1];
        w_sx = w_close ? r_cur_x   : r_prev_x;
        w_sy = w_close ? r_cur_y   : r_prev_y;
        w_sz = w_close ? r_cur_z   : r_prev_z;
        w_ex = w_close ? r_first_x : r_cur_x;
        w_ey = w_close ? r_first_y : r_cur_y;
        w_ez = w_close ? r_first_z : r_cur_z;
        w_num   = f_absdiff(w_sz, r_zlim);
        w_den   = f_absdiff(w_sz, w_ez);
        w_mag_x = f_absdiff(w_sx, w_ex);
        w_mag_y = f_absdiff(w_sy, w_ey);
        w_neg_x = $signed(w_ex) < $signed(w_sx);
        w_neg_y = $signed(w_ey) < $signed(w_sy);
    end

    // next pending slot, lowest first
    always_comb begin
        if (r_mask[0]) begin
            w_scan_slot = SLOT_CUT1;
        end else if (r_mask[1]) begin
            w_scan_slot = SLOT_END1;
        end else if (r_mask[2]) begin
            w_scan_slot = SLOT_CUT2;
        end else begin
            w_scan_slot = SLOT_END2;
        end
        w_rest = r_mask & ~(4'b0001 << w_scan_slot);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_zlim      = w_cfg_wr ? pwdata[CW-1:0] : r_zlim;
        n_in_poly   = r_in_poly;
        n_any       = r_any;
        n_last      = r_last;
        n_mask      = r_mask;
        n_slot      = r_slot;
        n_step_out  = r_step_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_cur_z     = r_cur_z;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_prev_z    = r_prev_z;
        n_first_x   = r_first_x;
        n_first_y   = r_first_y;
        n_first_z   = r_first_z;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_z     = r_res_z;
        n_res_has   = r_res_has;
        n_res_end   = r_res_end;
        n_res_empty = r_res_empty;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;
        n_out_has   = r_out_has;
        n_out_end   = r_out_end;
        n_out_empty = r_out_empty;
        w_md_req.start = 1'b0;
        w_md_req.num   = w_num;
        w_md_req.den   = w_den;
        w_md_req.mag   = w_mag_x;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cur_x    = i_vert_x;
                    n_cur_y    = i_vert_y;
                    n_cur_z    = i_vert_z;
                    n_last     = i_last_vertex;
                    n_step_out = 1'b0;
                    if (!r_in_poly) begin
                        n_first_x = i_vert_x;
                        n_first_y = i_vert_y;
                        n_first_z = i_vert_z;
                        n_any     = 1'b0;
                        n_in_poly = 1'b1;
                    end
                    n_mask[SLOT_CUT1] = r_in_poly && (w_vis_prev != w_vis_cur);
                    n_mask[SLOT_END1] = r_in_poly && w_vis_cur;
                    n_mask[SLOT_CUT2] = i_last_vertex && (w_vis_cur != w_vis_first);
                    n_mask[SLOT_END2] = i_last_vertex && w_vis_first;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_mask == '0) begin
                    if (r_last && !r_step_out) begin
                        // nothing from the closing vertex: end marker
                        n_res_x     = '0;
                        n_res_y     = '0;
                        n_res_z     = '0;
                        n_res_has   = 1'b0;
                        n_res_end   = 1'b1;
                        n_res_empty = !r_any;
                        n_state     = S_EMIT;
                    end else begin
                        n_prev_x  = r_cur_x;
                        n_prev_y  = r_cur_y;
                        n_prev_z  = r_cur_z;
                        n_in_poly = !r_last;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_slot      = w_scan_slot;
                    n_mask      = w_rest;
                    n_res_end   = r_last && (w_rest == '0);
                    n_res_has   = 1'b1;
                    n_res_empty = 1'b0;
                    if (w_scan_slot[0]) begin
                        // visible edge end
                        n_res_x = (w_scan_slot == SLOT_END2) ? r_first_x : r_cur_x;
                        n_res_y = (w_scan_slot == SLOT_END2) ? r_first_y : r_cur_y;
                        n_res_z = (w_scan_slot == SLOT_END2) ? r_first_z : r_cur_z;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_MDX;
                    end
                end
            end
            S_MDX: begin
                // slot is settled here, so operands are those of the crossing edge
                if (w_md_done) begin
                    n_res_x = w_neg_x ? (w_sx - w_md_quot[CW-1:0])
                                      : (w_sx + w_md_quot[CW-1:0]);
                    w_md_req.start = 1'b1;
                    w_md_req.mag   = w_mag_y;
                    n_state        = S_MDY;
                end
            end
            S_MDY: begin
                w_md_req.mag = w_mag_y;
                if (w_md_done) begin
                    n_res_y = w_neg_y ? (w_sy - w_md_quot[CW-1:0])
                                      : (w_sy + w_md_quot[CW-1:0]);
                    n_res_z = r_zlim;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_x     = r_res_x;
                    n_out_y     = r_res_y;
                    n_out_z     = r_res_z;
                    n_out_has   = r_res_has;
                    n_out_end   = r_res_end;
                    n_out_empty = r_res_empty;
                    n_out_valid = 1'b1;
                    n_step_out  = 1'b1;
                    if (r_res_has) begin
                        n_any = 1'b1;
                    end
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // first axis starts as the crossing slot is picked
        if (r_state == S_SCAN && r_mask != '0 && !w_scan_slot[0]) begin
            w_md_req.start = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zlim      <= pnc_pkg::ZLIM_RESET;
            r_in_poly   <= 1'b0;
            r_any       <= 1'b0;
            r_last      <= 1'b0;
            r_mask      <= '0;
            r_slot      <= SLOT_CUT1;
            r_step_out  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_zlim      <= n_zlim;
            r_in_poly   <= n_in_poly;
            r_any       <= n_any;
            r_last      <= n_last;
            r_mask      <= n_mask;
            r_slot      <= n_slot;
            r_step_out  <= n_step_out;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_cur_z     <= n_cur_z;
        r_prev_x    <= n_prev_x;
        r_prev_y    <= n_prev_y;
        r_prev_z    <= n_prev_z;
        r_first_x   <= n_first_x;
        r_first_y   <= n_first_y;
        r_first_z   <= n_first_z;
        r_res_x     <= n_res_x;
        r_res_y     <= n_res_y;
        r_res_z     <= n_res_z;
        r_res_has   <= n_res_has;
        r_res_end   <= n_res_end;
        r_res_empty <= n_res_empty;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_z     <= n_out_z;
        r_out_has   <= n_out_has;
        r_out_end   <= n_out_end;
        r_out_empty <= n_out_empty;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_z         = r_out_z;
    assign o_has_vertex    = r_out_has;
    assign o_polygon_end   = r_out_end;
    assign o_polygon_empty = r_out_empty;

endmodule

>>> verif/tb_polygon_near_plane_clip.sv
`timescale 1ns / 1ps

module tb_polygon_near_plane_clip;

    typedef logic signed [pnc_pkg::COORD_W-1:0] t_coord;

    // one clipped vertex or end marker as it leaves the block
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   has_vertex;
        logic   polygon_end;
        logic   polygon_empty;
    } t_clip_out;

    localparam logic [pnc_pkg::APB_ADDR_W-1:0] ADDR_UNUSED = pnc_pkg::APB_ADDR_W'(4);
    localparam t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN = 32'sh8000_0000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_coord i_vert_x = '0;
    t_coord i_vert_y = '0;
    t_coord i_vert_z = '0;
    logic i_last_vertex = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_coord o_out_x;
    t_coord o_out_y;
    t_coord o_out_z;
    logic o_has_vertex;
    logic o_polygon_end;
    logic o_polygon_empty;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pnc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // clipper shadow state
    t_coord plane_z = pnc_pkg::ZLIM_RESET;
    t_coord first_x = '0, first_y = '0, first_z = '0;
    t_coord prev_x = '0, prev_y = '0, prev_z = '0;
    bit in_polygon = 1'b0;
    bit any_emitted = 1'b0;
    t_clip_out step_out[$];
    t_clip_out clipped_due[$];

    bit calm_mode = 1'b0;
    int fail_count = 0;
    int cycle_count = 0;

    polygon_near_plane_clip uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_vert_x       (i_vert_x),
        .i_vert_y       (i_vert_y),
        .i_vert_z       (i_vert_z),
        .i_last_vertex  (i_last_vertex),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_has_vertex   (o_has_vertex),
        .o_polygon_end  (o_polygon_end),
        .o_polygon_empty(o_polygon_empty),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= calm_mode || ($urandom_range(0, 99) >= 7);
    end

    // compare each result request with the oldest prediction
    always @(posedge i_clk) begin
        t_clip_out seen;
        t_clip_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_out_x, o_out_y, o_out_z, o_has_vertex, o_polygon_end,
                     o_polygon_empty};
            if (clipped_due.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result x=%0d y=%0d z=%0d v=%b e=%b m=%b",
                             seen.x, seen.y, seen.z, seen.has_vertex,
                             seen.polygon_end, seen.polygon_empty);
                fail_count++;
            end else begin
                want = clipped_due.pop_front();
                if (seen !== want) begin
                    if (fail_count < 10)
                        $display({"mismatch exp x=%0d y=%0d z=%0d v=%b e=%b m=%b, ",
                                  "got x=%0d y=%0d z=%0d v=%b e=%b m=%b"},
                                 want.x, want.y, want.z, want.has_vertex,
                                 want.polygon_end, want.polygon_empty,
                                 seen.x, seen.y, seen.z, seen.has_vertex,
                                 seen.polygon_end, seen.polygon_empty);
                    fail_count++;
                end
            end
        end
    end

    // intersection coordinate on one axis, measured from the edge start
    function automatic t_coord cut_axis(t_coord a0, t_coord a1, logic [32:0] num,
                                        logic [32:0] den);
        longint diff;
        logic [65:0] mag;
        logic [65:0] off;
        diff = longint'(a1) - longint'(a0);
        mag = (diff < 0) ? 66'(-diff) : 66'(diff);
        off = ({33'b0, num} * mag) / {33'b0, den};
        return (diff < 0) ? t_coord'(a0 - off[31:0]) : t_coord'(a0 + off[31:0]);
    endfunction

    task automatic emit_vertex(t_coord x, t_coord y, t_coord z);
        t_clip_out res;
        res = '{x, y, z, 1'b1, 1'b0, 1'b0};
        step_out.insert(step_out.size(), res);
        any_emitted = 1'b1;
    endtask

    // clip one edge against the near plane
    task automatic clip_edge(t_coord sx, t_coord sy, t_coord sz,
                             t_coord ex, t_coord ey, t_coord ez);
        bit s_vis;
        bit e_vis;
        longint dn;
        longint dd;
        logic [32:0] num;
        logic [32:0] den;
        s_vis = (sz >= plane_z);
        e_vis = (ez >= plane_z);
        if (s_vis != e_vis) begin
            dn = longint'(plane_z) - longint'(sz);
            dd = longint'(ez) - longint'(sz);
            num = (dn < 0) ? 33'(-dn) : 33'(dn);
            den = (dd < 0) ? 33'(-dd) : 33'(dd);
            emit_vertex(cut_axis(sx, ex, num, den), cut_axis(sy, ey, num, den), plane_z);
        end
        if (e_vis)
            emit_vertex(ex, ey, ez);
    endtask

    // expected results for one accepted vertex
    task automatic predict_clip(t_coord x, t_coord y, t_coord z, bit last);
        t_clip_out marker;
        step_out.delete();
        if (!in_polygon) begin
            first_x = x;
            first_y = y;
            first_z = z;
            any_emitted = 1'b0;
            in_polygon = 1'b1;
        end else begin
            clip_edge(prev_x, prev_y, prev_z, x, y, z);
        end
        prev_x = x;
        prev_y = y;
        prev_z = z;
        if (last) begin
            clip_edge(x, y, z, first_x, first_y, first_z);
            if (step_out.size() > 0) begin
                step_out[step_out.size()-1].polygon_end = 1'b1;
            end else begin
                marker = '{'0, '0, '0, 1'b0, 1'b1, !any_emitted};
                step_out.insert(step_out.size(), marker);
            end
            in_polygon = 1'b0;
        end
        foreach (step_out[i])
            clipped_due.insert(clipped_due.size(), step_out[i]);
    endtask

    // send one vertex request and wait for it to be taken
    task automatic send_vertex(t_coord x, t_coord y, t_coord z, bit last);
        if (!calm_mode && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_vert_x <= x;
        i_vert_y <= y;
        i_vert_z <= z;
        i_last_vertex <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_clip(x, y, z, last);
    endtask

    // let the block run dry before touching the register
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (clipped_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [pnc_pkg::APB_ADDR_W-1:0] addr,
                              logic [31:0] data, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_plane_readback();
        logic [31:0] rd;
        apb_access(1'b0, pnc_pkg::ADDR_Z_LIMIT, '0, rd);
        if (rd !== plane_z) begin
            if (fail_count < 10)
                $display("z_limit readback exp %0d got %0d", plane_z, $signed(rd));
            fail_count++;
        end
    endtask

    task automatic set_plane(t_coord value);
        logic [31:0] rd;
        apb_access(1'b1, pnc_pkg::ADDR_Z_LIMIT, value, rd);
        plane_z = value;
        check_plane_readback();
    endtask

    // random depth, mostly close to the plane so that edges cross it
    function automatic t_coord pick_depth();
        int sel;
        int off;
        sel = $urandom_range(0, 9);
        off = int'($urandom_range(0, 2097152)) - 1048576;
        case (sel)
            0, 1, 2, 3: return plane_z + off;
            4: return plane_z;
            5: return plane_z - 1;
            6: return t_coord'($urandom);
            7: return COORD_MIN;
            8: return COORD_MAX;
            default: return plane_z + t_coord'($urandom) / 4;
        endcase
    endfunction

    // default plane, all vertices visible, extreme x and y
    task automatic test_visible_polygon();
        check_plane_readback();
        send_vertex(COORD_MAX, COORD_MIN, 32'sd65536, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(32'sd0, -32'sd1, 32'sd200000, 1'b1);
        wait_drained();
    endtask

    // polygon entirely behind the plane gives the empty marker
    task automatic test_hidden_polygon();
        send_vertex(32'sd100, 32'sd200, 32'sd65535, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, 32'sd5, 32'sd0, 1'b1);
        wait_drained();
    endtask

    // single-vertex polygons, visible then hidden
    task automatic test_single_vertex();
        send_vertex(-32'sd5, 32'sd7, 32'sd65536, 1'b1);
        send_vertex(32'sd9, -32'sd3, 32'sd0, 1'b1);
        wait_drained();
    endtask

    // last step yields nothing after earlier output: marker not empty
    task automatic test_closing_marker();
        send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_vertex(32'sh0010_0000, 32'sh0010_0000, 32'sh0020_0000, 1'b0);
        send_vertex(32'sh0020_0000, 32'sd0, 32'sd0, 1'b0);
        send_vertex(32'sh0010_0000, -32'sh0010_0000, -32'sh0001_0000, 1'b1);
        wait_drained();
    endtask

    // widest crossings and the plane at its limits
    task automatic test_plane_extremes();
        logic [31:0] rd;
        set_plane(32'sd0);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(32'sd0, 32'sd0, -32'sd1, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(32'sd1, -32'sd1, 32'sd0, 1'b1);
        wait_drained();
        set_plane(COORD_MAX);
        send_vertex(32'sd1, 32'sd2, COORD_MAX, 1'b0);
        send_vertex(32'sd3, 32'sd4, COORD_MAX - 1, 1'b0);
        send_vertex(32'sd5, 32'sd6, COORD_MIN, 1'b1);
        wait_drained();
        set_plane(COORD_MIN);
        send_vertex(COORD_MIN, 32'sd2, COORD_MIN, 1'b0);
        send_vertex(32'sd3, COORD_MAX, 32'sd0, 1'b0);
        send_vertex(-32'sd7, 32'sd6, COORD_MAX, 1'b1);
        wait_drained();
        // a write to an unused address leaves the plane alone
        apb_access(1'b1, ADDR_UNUSED, $urandom, rd);
        check_plane_readback();
    endtask

    // random polygons under one plane setting
    task automatic test_random_polygons(t_coord plane, int n_items, bit calm);
        int sent;
        int len;
        set_plane(plane);
        calm_mode = calm;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_vertex(t_coord'($urandom), t_coord'($urandom), pick_depth(),
                            k == len - 1);
            sent += len;
        end
        wait_drained();
        calm_mode = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_visible_polygon();
        test_hidden_polygon();
        test_single_vertex();
        test_closing_marker();
        test_plane_extremes();
        test_random_polygons(pnc_pkg::ZLIM_RESET, 100, 1'b0);
        test_random_polygons(32'sd0, 100, 1'b1);
        test_random_polygons(t_coord'($urandom), 80, 1'b0);
        test_random_polygons(COORD_MAX, 50, 1'b0);
        test_random_polygons(COORD_MIN, 40, 1'b0);
        test_random_polygons(t_coord'(int'($urandom_range(0, 4194304)) - 2097152), 40,
                             1'b0);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> polygon_near_plane_clip.f
hw/rtl/pnc_pkg.sv
hw/rtl/pnc_muldiv.sv
hw/rtl/polygon_near_plane_clip.sv
verif/tb_polygon_near_plane_clip.sv
